FILE: src/atp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atp_pkg
// Shared constants and the arctangent table for the tilt angle pipeline.
// ----------------------------------------------------------------------------
package atp_pkg;

    // Angle word width in binary angle units (2^32 per turn), with headroom
    // for the half-turn offset and the quarter-turn subtraction of yaw.
    localparam int ZW = 35;

    localparam logic signed [ZW-1:0] HALF_TURN    = ZW'(64'h0000_0000_8000_0000);
    localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'h0000_0000_4000_0000);

    // atan(2^-i) in binary angle units.
    function automatic logic [31:0] atan_bam(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            5'd31: v = 32'h00000000;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

FILE: src/atp_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atp_scale
// Scales one raw axis count to milli-g: raw * 39 / 10, truncated toward zero.
// ----------------------------------------------------------------------------
module atp_scale #(
    parameter int SB = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 vld_in,
    input  logic [SB-1:0]        raw,
    output logic                 vld_out,
    output logic signed [SB+2:0] g
);
    localparam int MW = SB + 5;
    localparam int K  = MW + 4;
    localparam int RW = K - 3;
    localparam int QW = MW - 3;
    localparam logic [RW-1:0] RECIP = RW'((64'd1 << K) / 64'd10);

    logic signed [MW:0]   rx;
    logic signed [MW:0]   p;
    logic [MW-1:0]        mag_reg, mag2_reg;
    logic                 neg_reg, neg2_reg;
    logic [QW-1:0]        q0_reg;
    logic [MW+RW-1:0]     prod;
    logic [MW-1:0]        rem;
    logic [QW-1:0]        q;
    logic signed [SB+2:0] g_next, g_reg;
    logic [2:0]           vld_reg;

    assign rx   = $signed({{(MW+1-SB){raw[SB-1]}}, raw});
    assign p    = (rx <<< 5) + (rx <<< 2) + (rx <<< 1) + rx;
    assign prod = mag_reg * RECIP;

    // The reciprocal is slightly low, so the estimate is at most one short.
    always_comb begin
        rem    = mag2_reg - {q0_reg, 3'b000} - {2'b00, q0_reg, 1'b0};
        q      = (rem >= MW'(10)) ? q0_reg + QW'(1) : q0_reg;
        g_next = neg2_reg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], vld_in};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_reg  <= p[MW];
            mag_reg  <= p[MW] ? MW'(-p) : p[MW-1:0];
            q0_reg   <= prod[MW+RW-1:K];
            mag2_reg <= mag_reg;
            neg2_reg <= neg_reg;
            g_reg    <= g_next;
        end
    end

    assign vld_out = vld_reg[2];
    assign g       = g_reg;
endmodule

FILE: src/atp_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atp_sqrt
// Pitch denominator floor(sqrt((gy^2 + gz^2) * 4096)), one root bit per stage,
// with the other sample fields carried alongside.
// ----------------------------------------------------------------------------
module atp_sqrt #(
    parameter int SB = 16,
    parameter int SW = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 vld_in,
    input  logic signed [SB+2:0] gy,
    input  logic signed [SB+2:0] gz,
    input  logic [SW-1:0]        side_in,
    output logic                 vld_out,
    output logic [SB+8:0]        root,
    output logic [SW-1:0]        side_out
);
    localparam int GW = SB + 3;
    localparam int RB = SB + 9;
    localparam int NW = 2 * RB;

    logic [2*GW-1:0] sqy_reg, sqz_reg;
    logic [2*GW:0]   sum;
    logic [SW-1:0]   side0_reg;
    logic            vld0_reg;

    logic [NW-1:0]   n_reg    [0:RB];
    logic [RB+1:0]   rem_reg  [0:RB];
    logic [RB-1:0]   root_reg [0:RB];
    logic [SW-1:0]   side_reg [0:RB];
    logic            vld_reg  [0:RB];

    assign sum = {1'b0, sqy_reg} + {1'b0, sqz_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld0_reg   <= 1'b0;
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld0_reg   <= vld_in;
            vld_reg[0] <= vld0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sqy_reg     <= (2*GW)'(gy * gy);
            sqz_reg     <= (2*GW)'(gz * gz);
            side0_reg   <= side_in;
            n_reg[0]    <= {sum[NW-13:0], 12'd0};
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            side_reg[0] <= side0_reg;
        end
    end

    for (genvar k = 0; k < RB; k++) begin : g_stage
        logic [RB+3:0] cur, trial, diff;
        logic [RB+1:0] rem_next;
        logic [RB-1:0] root_next;

        always_comb begin
            cur   = {rem_reg[k], n_reg[k][NW-1:NW-2]};
            trial = {2'b00, root_reg[k], 2'b01};
            diff  = cur - trial;
            if (cur >= trial) begin
                rem_next  = diff[RB+1:0];
                root_next = {root_reg[k][RB-2:0], 1'b1};
            end else begin
                rem_next  = cur[RB+1:0];
                root_next = {root_reg[k][RB-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[k+1]    <= {n_reg[k][NW-3:0], 2'b00};
                rem_reg[k+1]  <= rem_next;
                root_reg[k+1] <= root_next;
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign vld_out  = vld_reg[RB];
    assign root     = root_reg[RB];
    assign side_out = side_reg[RB];
endmodule

FILE: src/atp_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atp_cordic
// One vectoring CORDIC lane: atan2(num, den) in binary angle units, one
// micro-rotation per pipeline stage.
// ----------------------------------------------------------------------------
module atp_cordic #(
    parameter int SB     = 16,
    parameter int STAGES = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         vld_in,
    input  logic                         tag_in,
    input  logic signed [SB+9:0]         num,
    input  logic signed [SB+9:0]         den,
    output logic                         vld_out,
    output logic                         tag_out,
    output logic signed [atp_pkg::ZW-1:0] angle
);
    import atp_pkg::*;

    localparam int OW = SB + 10;
    localparam int W  = SB + 36;

    logic signed [W-1:0]  x0, y0;
    logic signed [W-1:0]  x_reg    [0:STAGES];
    logic signed [W-1:0]  y_reg    [0:STAGES];
    logic signed [ZW-1:0] z_reg    [0:STAGES];
    logic                 zero_reg [0:STAGES];
    logic                 tag_reg  [0:STAGES];
    logic                 vld_reg  [0:STAGES];

    assign x0 = $signed({{(W-OW-24){den[OW-1]}}, den, 24'd0});
    assign y0 = $signed({{(W-OW-24){num[OW-1]}}, num, 24'd0});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= vld_in;
        end
    end

    // A vector in the left half-plane is first turned by a half turn.
    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= (num == '0) && (den == '0);
            tag_reg[0]  <= tag_in;
            if (x0 < 0) begin
                x_reg[0] <= -x0;
                y_reg[0] <= -y0;
                z_reg[0] <= (y0 >= 0) ? HALF_TURN : -HALF_TURN;
            end else begin
                x_reg[0] <= x0;
                y_reg[0] <= y0;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic signed [ZW-1:0] ATAN = $signed({{(ZW-32){1'b0}}, atan_bam(5'(i))});
        logic signed [W-1:0] dx, dy;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                zero_reg[i+1] <= zero_reg[i];
                tag_reg[i+1]  <= tag_reg[i];
                if (y_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + ATAN;
                end else begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - ATAN;
                end
            end
        end
    end

    assign vld_out = vld_reg[STAGES];
    assign tag_out = tag_reg[STAGES];
    assign angle   = zero_reg[STAGES] ? '0 : z_reg[STAGES];
endmodule

FILE: src/atp_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atp_merge
// Combines the three lane angles into degrees with saturation and holds the
// finished items in a two-entry output buffer.
// ----------------------------------------------------------------------------
module atp_merge #(
    parameter int F = 7
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          vld_in,
    input  logic                          undef_in,
    input  logic signed [atp_pkg::ZW-1:0] z_pitch,
    input  logic signed [atp_pkg::ZW-1:0] z_roll,
    input  logic signed [atp_pkg::ZW-1:0] z_yaw,
    output logic                          full,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [3*F+26:0]               out_data,
    output logic                          out_undef
);
    import atp_pkg::*;

    localparam int TW = ZW + 7 + F;
    localparam int VW = TW - 28;
    localparam int PW = F + 8;
    localparam int RW = F + 9;
    localparam int YW = F + 10;
    localparam int DW = PW + RW + YW;

    logic [ZW-1:0] mp_reg, mr_reg, my_reg;
    logic          np_reg, nr_reg, ny_reg;
    logic          undef_reg, vld_reg;
    logic signed [ZW-1:0] bam_y;
    logic signed [VW-1:0] vp, vr, vy;

    logic [DW:0]   buf_reg [0:1];
    logic          rd_reg, wr_reg;
    logic [1:0]    cnt_reg;
    logic          push, pop;

    function automatic logic signed [VW-1:0] to_fixed(
        input logic [ZW-1:0] mag,
        input logic          neg,
        input int            lo_deg,
        input int            hi_deg
    );
        logic [ZW+5:0]         m45;
        logic [TW-1:0]         t;
        logic signed [VW-1:0]  v, lo, hi;
        m45 = {1'b0, mag, 5'd0} + {3'd0, mag, 3'd0} + {4'd0, mag, 2'd0} + {6'd0, mag};
        t   = {1'b0, m45, {F{1'b0}}} + (TW'(1) << 28);
        v   = $signed({1'b0, t[TW-1:29]});
        if (neg) begin
            v = -v;
        end
        lo = VW'(lo_deg) <<< F;
        hi = VW'(hi_deg) <<< F;
        if (v < lo) begin
            v = lo;
        end
        if (v > hi) begin
            v = hi;
        end
        return v;
    endfunction

    assign bam_y = z_yaw - QUARTER_TURN;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            np_reg    <= z_pitch[ZW-1];
            nr_reg    <= z_roll[ZW-1];
            ny_reg    <= bam_y[ZW-1];
            mp_reg    <= z_pitch[ZW-1] ? ZW'(-z_pitch) : ZW'(z_pitch);
            mr_reg    <= z_roll[ZW-1] ? ZW'(-z_roll) : ZW'(z_roll);
            my_reg    <= bam_y[ZW-1] ? ZW'(-bam_y) : ZW'(bam_y);
            undef_reg <= undef_in;
        end
    end

    assign vp = to_fixed(mp_reg, np_reg, -90, 90);
    assign vr = to_fixed(mr_reg, nr_reg, -180, 180);
    assign vy = to_fixed(my_reg, ny_reg, -270, 90);

    // The pipeline only advances while the buffer has room, so a push
    // never meets a full buffer.
    assign push = en && vld_reg;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wr_reg <= ~wr_reg;
            end
            if (pop) begin
                rd_reg <= ~rd_reg;
            end
            unique case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_reg] <= {undef_reg, vy[YW-1:0], vr[RW-1:0], vp[PW-1:0]};
        end
    end

    assign full      = (cnt_reg == 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = buf_reg[rd_reg][DW-1:0];
    assign out_undef = buf_reg[rd_reg][DW];
endmodule

FILE: src/accel_tilt_angles_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_tilt_angles_top
// Pitch, roll and yaw from one three-axis accelerometer sample.
// ----------------------------------------------------------------------------
//  Channel  Dir  Fields (tdata from bit 0 up)            tuser
//  s_       in   accel_x, accel_y, accel_z               -
//  m_       out  pitch_deg, roll_deg, yaw_deg            pitch_undefined
//
// One item per cycle enters the pipeline while s_tready is high. From
// acceptance to the output register an item passes scaling, the square
// root (one root bit per stage), the CORDIC lanes and degree conversion.
// Reset is synchronous and only clears the valid flags, buffer pointers
// and buffer count. A two-entry output buffer absorbs stalls; s_tready
// drops only while both entries are full, and then the whole pipeline holds.
// ----------------------------------------------------------------------------
module accel_tilt_angles_top #(
    parameter int SAMPLE_BITS     = 16,
    parameter int ANGLE_FRAC_BITS = 7,
    parameter int CORDIC_STAGES   = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // accel_x, accel_y, accel_z, zero padding
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // pitch_deg, roll_deg, yaw_deg, zero padding
    output logic [((3*ANGLE_FRAC_BITS+27+7)/8)*8-1:0] m_tdata,
    // pitch_undefined
    output logic m_tuser
);
    import atp_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int F   = ANGLE_FRAC_BITS;
    localparam int GW  = SB + 3;
    localparam int OW  = SB + 10;
    localparam int SW  = 3 * GW + 1;
    localparam int DW  = 3 * F + 27;
    localparam int ODW = ((DW + 7) / 8) * 8;

    logic                 en, full;
    logic                 sc_vld, sq_vld, co_vld;
    logic signed [GW-1:0] gx, gy, gz;
    logic signed [GW-1:0] dgx, dgy, dgz;
    logic                 dundef, co_undef;
    logic [SW-1:0]        side;
    logic [SB+8:0]        root;
    logic signed [OW-1:0] xs, ys, zs;
    logic signed [ZW-1:0] z_pitch, z_roll, z_yaw;
    logic [DW-1:0]        out_data;

    assign en       = !full;
    assign s_tready = en;

    atp_scale #(.SB(SB)) u_scale_x (
        .aclk(aclk), .aresetn(aresetn), .en(en), .vld_in(s_tvalid),
        .raw(s_tdata[SB-1:0]), .vld_out(sc_vld), .g(gx)
    );
    atp_scale #(.SB(SB)) u_scale_y (
        .aclk(aclk), .aresetn(aresetn), .en(en), .vld_in(s_tvalid),
        .raw(s_tdata[2*SB-1:SB]), .vld_out(), .g(gy)
    );
    atp_scale #(.SB(SB)) u_scale_z (
        .aclk(aclk), .aresetn(aresetn), .en(en), .vld_in(s_tvalid),
        .raw(s_tdata[3*SB-1:2*SB]), .vld_out(), .g(gz)
    );

    atp_sqrt #(.SB(SB), .SW(SW)) u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .en(en), .vld_in(sc_vld),
        .gy(gy), .gz(gz),
        .side_in({(gx == '0) && (gy == '0) && (gz == '0), gz, gy, gx}),
        .vld_out(sq_vld), .root(root), .side_out(side)
    );

    assign dgx    = side[GW-1:0];
    assign dgy    = side[2*GW-1:GW];
    assign dgz    = side[3*GW-1:2*GW];
    assign dundef = side[SW-1];

    // Scaled axes times 64, sign-extended to the lane operand width.
    assign xs = $signed({{(OW-GW-6){dgx[GW-1]}}, dgx, 6'd0});
    assign ys = $signed({{(OW-GW-6){dgy[GW-1]}}, dgy, 6'd0});
    assign zs = $signed({{(OW-GW-6){dgz[GW-1]}}, dgz, 6'd0});

    atp_cordic #(.SB(SB), .STAGES(CORDIC_STAGES)) u_lane_pitch (
        .aclk(aclk), .aresetn(aresetn), .en(en), .vld_in(sq_vld), .tag_in(dundef),
        .num(xs), .den($signed({1'b0, root})),
        .vld_out(co_vld), .tag_out(co_undef), .angle(z_pitch)
    );
    atp_cordic #(.SB(SB), .STAGES(CORDIC_STAGES)) u_lane_roll (
        .aclk(aclk), .aresetn(aresetn), .en(en), .vld_in(sq_vld), .tag_in(1'b0),
        .num(ys), .den(zs), .vld_out(), .tag_out(), .angle(z_roll)
    );
    atp_cordic #(.SB(SB), .STAGES(CORDIC_STAGES)) u_lane_yaw (
        .aclk(aclk), .aresetn(aresetn), .en(en), .vld_in(sq_vld), .tag_in(1'b0),
        .num(zs), .den(xs), .vld_out(), .tag_out(), .angle(z_yaw)
    );

    atp_merge #(.F(F)) u_merge (
        .aclk(aclk), .aresetn(aresetn), .en(en), .vld_in(co_vld), .undef_in(co_undef),
        .z_pitch(z_pitch), .z_roll(z_roll), .z_yaw(z_yaw),
        .full(full), .out_valid(m_tvalid), .out_ready(m_tready),
        .out_data(out_data), .out_undef(m_tuser)
    );

    assign m_tdata = ODW'(out_data);

    // An all-zero sample must come out with pitch forced to zero.
    a_undef_pitch_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (out_data[F+7:0] == '0))
        else $error("pitch not zero on an undefined item");

    // Input stalls only while the output buffer is full.
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with an empty output buffer");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_yaw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (($signed(out_data[DW-1:2*F+17]) >= -($signed(18'(270)) <<< F))
                   && ($signed(out_data[DW-1:2*F+17]) <= ($signed(18'(90)) <<< F))))
        else $error("yaw out of range");
endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the accelerometer tilt angle pipeline.
// ----------------------------------------------------------------------------
// Raw three-axis samples are streamed in. First comes a short directed set:
// the axis extremes, zero vectors and small nonzero counts. Random
// samples follow. Each accepted sample is run through a bit-exact angle
// model: scaling, integer square root, CORDIC vectoring and degree
// conversion with saturation. Every returned item is compared field by
// field with the oldest predicted angle set. Both sides of the stream idle
// at random, at rates set by thirds of the run and none in the last third,
// and at one point the input pauses until the pipeline has drained.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NUM_RANDOM   = 1430;
    localparam int HOLD_AT      = 700;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 80;
    localparam int NUM_STAGES   = 16;
    localparam int FRAC         = 7;

    typedef struct packed {
        logic signed [16:0] yaw;
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic               undef;
    } angles_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;

    logic [47:0] sample_q[$];
    angles_t     angle_q[$];
    int          sent_cnt = 0;
    int          total_items = 0;
    int          cycle_cnt = 0;
    int          mismatch_cnt = 0;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          drained = 1'b0;

    accel_tilt_angles_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 aclk = ~aclk;

    function automatic longint atan_step(input int idx);
        longint tbl[16] = '{
            64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
            64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
            64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
            64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};
        return tbl[idx];
    endfunction

    function automatic longint unsigned isqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Vectoring CORDIC; result in binary angle units, 2^32 per turn.
    function automatic longint vector_angle(input longint num, input longint den);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        z = 0;
        if (num == 0 && den == 0) return 0;
        x = den <<< 24;
        y = num <<< 24;
        if (x < 0) begin
            z = (y >= 0) ? 64'sd2147483648 : -64'sd2147483648;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < NUM_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx;
                y -= dy;
                z += atan_step(i);
            end else begin
                x -= dx;
                y += dy;
                z -= atan_step(i);
            end
        end
        return z;
    endfunction

    function automatic longint to_degrees(input longint bam, input longint lo_deg,
                                          input longint hi_deg);
        longint unsigned m;
        longint v;
        m = (bam < 0) ? -bam : bam;
        m = (m * 45) << FRAC;
        m = (m + (64'd1 << 28)) >> 29;
        v = (bam < 0) ? -longint'(m) : longint'(m);
        if (v < lo_deg * (1 << FRAC)) v = lo_deg * (1 << FRAC);
        if (v > hi_deg * (1 << FRAC)) v = hi_deg * (1 << FRAC);
        return v;
    endfunction

    function automatic angles_t tilt_angles(input logic [47:0] sample);
        longint gx;
        longint gy;
        longint gz;
        longint root;
        angles_t a;
        gx = longint'($signed(sample[15:0])) * 39 / 10;
        gy = longint'($signed(sample[31:16])) * 39 / 10;
        gz = longint'($signed(sample[47:32])) * 39 / 10;
        root = longint'(isqrt(longint'(gy * gy + gz * gz) << 12));
        a.undef = (gx == 0 && gy == 0 && gz == 0);
        a.pitch = a.undef ? '0 : 15'(to_degrees(vector_angle(gx * 64, root), -90, 90));
        a.roll  = 16'(to_degrees(vector_angle(gy * 64, gz * 64), -180, 180));
        a.yaw   = 17'(to_degrees(vector_angle(gz * 64, gx * 64) - 64'sd1073741824,
                                 -270, 90));
        return a;
    endfunction

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return 16'($urandom);
            5, 6: return 16'($signed($urandom_range(40)) - 20);
            7: return 16'($signed($urandom_range(600)) - 300);
            8: return '0;
            default: return ($urandom_range(1)) ? 16'h8000 : 16'h7FFF;
        endcase
    endfunction

    always_comb begin
        if (sent_cnt < total_items / 3) begin
            send_idle_pct = 27;
            recv_idle_pct = 65;
        end else if (sent_cnt < (2 * total_items) / 3) begin
            send_idle_pct = 65;
            recv_idle_pct = 27;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    // Driver and input-side prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                angle_q.push_back(tilt_angles(s_tdata));
                sent_cnt <= sent_cnt + 1;
            end
            if (sent_cnt >= HOLD_AT && !drained && angle_q.size() == 0 && !s_tvalid)
                drained <= 1'b1;
            if (!s_tvalid || s_tready) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct
                    && !(sent_cnt + (s_tvalid ? 1 : 0) >= HOLD_AT && !drained)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= sample_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor and checker.
    always @(posedge aclk) begin
        angles_t want;
        angles_t got;
        cycle_cnt <= cycle_cnt + 1;
        if (aresetn) m_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_tvalid && m_tready) begin
            got.pitch = m_tdata[14:0];
            got.roll  = m_tdata[30:15];
            got.yaw   = m_tdata[47:31];
            got.undef = m_tuser;
            if (angle_q.size() == 0) begin
                mismatch_cnt <= mismatch_cnt + 1;
                if (mismatch_cnt < 10) $display("Unexpected result item: %h", m_tdata);
            end else begin
                want = angle_q.pop_front();
                if (got !== want) begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < 10)
                        $display("Mismatch: pitch %0d/%0d roll %0d/%0d yaw %0d/%0d undef %0d/%0d",
                                 want.pitch, got.pitch, want.roll, got.roll,
                                 want.yaw, got.yaw, want.undef, got.undef);
                end
            end
        end
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] az;
        logic [15:0] edges[5];
        edges = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF};
        // Extremes of every axis, combined with zero and small values.
        for (int i = 0; i < 5; i++)
            sample_q.push_back({edges[(i + 2) % 5], edges[(i + 1) % 5], edges[i]});
        sample_q.push_back(48'h0);
        // Small nonzero raw counts on every axis.
        sample_q.push_back({16'hFFFE, 16'h0002, 16'h0001});
        // Horizontal component zero, X positive and negative.
        sample_q.push_back({16'h0000, 16'h0000, 16'h1234});
        sample_q.push_back({16'h0000, 16'h0000, 16'h8000});
        // Negative X with Y zero, Z zero, positive and negative: half-turn start.
        sample_q.push_back({16'h0000, 16'h0000, 16'hF000});
        sample_q.push_back({16'h0100, 16'h0000, 16'hF000});
        sample_q.push_back({16'hFF00, 16'h0000, 16'hF000});
        sample_q.push_back({16'h8000, 16'h0100, 16'h0000});
        sample_q.push_back({16'h8000, 16'hFF00, 16'h0000});
        sample_q.push_back({16'h8000, 16'h8000, 16'h8000});
        sample_q.push_back({16'h7FFF, 16'h7FFF, 16'h7FFF});
        sample_q.push_back({16'h7FFF, 16'h8000, 16'h7FFF});
        sample_q.push_back({16'h0000, 16'h7FFF, 16'h0000});
        for (int i = 0; i < NUM_RANDOM; i++) begin
            ax = rand_axis();
            ay = rand_axis();
            az = rand_axis();
            sample_q.push_back({az, ay, ax});
        end
        total_items = sample_q.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (sample_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (angle_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0 && angle_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
